// ===== design/kpc_pkg.sv =====
// Shared constants and command codes for the keyed program cache.
package kpc_pkg;

    localparam int KEY_W       = 64;
    localparam int CF_W        = 24;
    localparam int SLOT_W      = 8;
    localparam int MAX_STAGES  = 8;
    localparam int ENTRIES_DEF = 256;
    localparam int STAGES_DEF  = 8;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

endpackage

// ===== design/keyed_program_cache_fifo.sv =====
// Top level of the keyed program cache: fully associative key store with FIFO replacement.
// A clear or an unchanged request passes S_CHECK and S_DONE and then enters the output
// register; a look-up reads one entry per cycle in S_WALK, up to a match or, on a miss, to the
// last filled entry. The block takes one word at a time; the next word is accepted in the cycle
// after its result enters the output register, and S_DONE waits while a held result is stalled. Reset
// clears the fill count, the victim pointer and the last-key record; the key RAM is not.
module keyed_program_cache_fifo
#(
    parameter int ENTRIES = kpc_pkg::ENTRIES_DEF,
    parameter int STAGES  = kpc_pkg::STAGES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic                       cmd,
    input  logic [kpc_pkg::KEY_W-1:0]  program_key,
    input  logic [kpc_pkg::KEY_W-1:0]  stage_key_0,
    input  logic [kpc_pkg::KEY_W-1:0]  stage_key_1,
    input  logic [kpc_pkg::KEY_W-1:0]  stage_key_2,
    input  logic [kpc_pkg::KEY_W-1:0]  stage_key_3,
    input  logic [kpc_pkg::KEY_W-1:0]  stage_key_4,
    input  logic [kpc_pkg::KEY_W-1:0]  stage_key_5,
    input  logic [kpc_pkg::KEY_W-1:0]  stage_key_6,
    input  logic [kpc_pkg::KEY_W-1:0]  stage_key_7,
    input  logic [kpc_pkg::CF_W-1:0]   coord_formats,

    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [kpc_pkg::SLOT_W-1:0] slot,
    output logic                       hit,
    output logic                       unchanged,
    output logic                       evicted
);

    import kpc_pkg::*;

    // Index width, fill-count width (it must hold ENTRIES itself), and the layout of one
    // stored entry: program key in the low bits, then the stage keys, then the formats.
    localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW  = IW + 1;
    localparam int PSW = KEY_W * (STAGES + 1);
    localparam int EW  = PSW + CF_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     filled_count_reg, filled_count_next;
    logic [IW-1:0]     next_victim_reg, next_victim_next;
    logic [PSW-1:0]    last_key_reg, last_key_next;
    logic              last_valid_reg, last_valid_next;
    logic [SLOT_W-1:0] last_slot_reg, last_slot_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Request captured at acceptance, and the result waiting for the output register.
    logic              req_cmd_reg;
    logic [EW-1:0]     req_key_reg;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_hit_reg, res_hit_next;
    logic              res_unch_reg, res_unch_next;
    logic              res_evict_reg, res_evict_next;

    logic [SLOT_W-1:0] slot_reg;
    logic              hit_reg;
    logic              unchanged_reg;
    logic              evicted_reg;

    logic [KEY_W-1:0]  stage_in [MAX_STAGES];
    logic [EW-1:0]     in_word;
    logic              req_accept;
    logic              rsp_load;
    logic              do_miss;

    logic              wr_en;
    logic [IW-1:0]     rd_addr;
    logic [EW-1:0]     rd_data;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;

    assign rsp_valid = rsp_valid_reg;
    assign slot      = slot_reg;
    assign hit       = hit_reg;
    assign unchanged = unchanged_reg;
    assign evicted   = evicted_reg;

    assign stage_in[0] = stage_key_0;
    assign stage_in[1] = stage_key_1;
    assign stage_in[2] = stage_key_2;
    assign stage_in[3] = stage_key_3;
    assign stage_in[4] = stage_key_4;
    assign stage_in[5] = stage_key_5;
    assign stage_in[6] = stage_key_6;
    assign stage_in[7] = stage_key_7;

    // Pack the request into the same layout as a stored entry; only the first STAGES stage
    // keys take part.
    always_comb
    begin
        in_word = '0;
        in_word[KEY_W-1:0] = program_key;
        for (int s = 0; s < STAGES; s++)
        begin
            in_word[KEY_W*(s+1) +: KEY_W] = stage_in[s];
        end
        in_word[EW-1 -: CF_W] = coord_formats;
    end

    // The whole key store is one wide RAM, one entry per row, so the walk reads and compares
    // a complete key every cycle. A miss writes the request at the victim row.
    kpc_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (next_victim_reg),
        .wr_data (req_key_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        filled_count_next = filled_count_reg;
        next_victim_next  = next_victim_reg;
        last_key_next     = last_key_reg;
        last_valid_next   = last_valid_reg;
        last_slot_next    = last_slot_reg;
        res_slot_next     = res_slot_reg;
        res_hit_next      = res_hit_reg;
        res_unch_next     = res_unch_reg;
        res_evict_next    = res_evict_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        rsp_load          = 1'b0;
        do_miss           = 1'b0;
        wr_en             = 1'b0;
        rd_addr           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (req_cmd_reg == CMD_CLEAR)
                begin
                    filled_count_next = '0;
                    next_victim_next  = '0;
                    last_valid_next   = 1'b0;
                    last_slot_next    = '0;
                    res_slot_next     = '0;
                    res_hit_next      = 1'b0;
                    res_unch_next     = 1'b0;
                    res_evict_next    = 1'b0;
                    state_next        = S_DONE;
                end
                else if (last_valid_reg && (req_key_reg[PSW-1:0] == last_key_reg))
                begin
                    // The formats are not compared here, and the store is left alone.
                    res_slot_next  = last_slot_reg;
                    res_hit_next   = 1'b1;
                    res_unch_next  = 1'b1;
                    res_evict_next = 1'b0;
                    state_next     = S_DONE;
                end
                else if (filled_count_reg == '0)
                begin
                    do_miss = 1'b1;
                end
                else
                begin
                    rd_addr    = '0;
                    idx_next   = '0;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                // rd_data holds entry idx_reg, read in the previous cycle.
                if (rd_data == req_key_reg)
                begin
                    res_slot_next   = SLOT_W'(idx_reg);
                    res_hit_next    = 1'b1;
                    res_unch_next   = 1'b0;
                    res_evict_next  = 1'b0;
                    last_key_next   = req_key_reg[PSW-1:0];
                    last_valid_next = 1'b1;
                    last_slot_next  = SLOT_W'(idx_reg);
                    state_next      = S_DONE;
                end
                else if ((CW'(idx_reg) + CW'(1)) < filled_count_reg)
                begin
                    idx_next = idx_reg + IW'(1);
                    rd_addr  = idx_reg + IW'(1);
                end
                else
                begin
                    do_miss = 1'b1;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A miss takes the round-robin victim row; it is an eviction once the store is full.
        if (do_miss)
        begin
            wr_en          = 1'b1;
            res_slot_next  = SLOT_W'(next_victim_reg);
            res_hit_next   = 1'b0;
            res_unch_next  = 1'b0;
            res_evict_next = (filled_count_reg == CW'(ENTRIES));
            if (filled_count_reg < CW'(ENTRIES))
            begin
                filled_count_next = filled_count_reg + CW'(1);
            end
            if (next_victim_reg == IW'(ENTRIES - 1))
            begin
                next_victim_next = '0;
            end
            else
            begin
                next_victim_next = next_victim_reg + IW'(1);
            end
            last_key_next   = req_key_reg[PSW-1:0];
            last_valid_next = 1'b1;
            last_slot_next  = SLOT_W'(next_victim_reg);
            state_next      = S_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            filled_count_reg <= '0;
            next_victim_reg  <= '0;
            last_key_reg     <= '0;
            last_valid_reg   <= 1'b0;
            last_slot_reg    <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            filled_count_reg <= filled_count_next;
            next_victim_reg  <= next_victim_next;
            last_key_reg     <= last_key_next;
            last_valid_reg   <= last_valid_next;
            last_slot_reg    <= last_slot_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_cmd_reg <= cmd;
            req_key_reg <= in_word;
        end
        res_slot_reg  <= res_slot_next;
        res_hit_reg   <= res_hit_next;
        res_unch_reg  <= res_unch_next;
        res_evict_reg <= res_evict_next;
        if (rsp_load)
        begin
            slot_reg      <= res_slot_reg;
            hit_reg       <= res_hit_reg;
            unchanged_reg <= res_unch_reg;
            evicted_reg   <= res_evict_reg;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_count_reg <= CW'(ENTRIES))
        else $error("fill count exceeds the number of entries");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (CW'(idx_reg) < filled_count_reg))
        else $error("walk index beyond the filled entries");

    a_write_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> ((state_reg == S_DONE) && last_valid_reg))
        else $error("store write not followed by a result");

    a_unchanged_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && unchanged_reg) |-> (hit_reg && !evicted_reg))
        else $error("unchanged result without hit or with eviction");

    a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (filled_count_reg != CW'(ENTRIES))) |=>
            (filled_count_reg == $past(filled_count_reg) + CW'(1)))
        else $error("miss into a free entry did not grow the fill count");

endmodule

// ===== design/kpc_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
module kpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
